// ===== hdl/char_lcd_nibble_interface_defines.svh =====
// Assertion macros for the character LCD nibble interface.
// Included by the top level; no other dependencies.
`ifndef CHAR_LCD_NIBBLE_INTERFACE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define CLN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Expression must never be true outside reset.
`define CLN_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define CLN_ASSERT(label, clk, rst, prop, msg)
`define CLN_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

// ===== hdl/cln_pkg.sv =====
// Shared types, codes and helper functions for the character LCD nibble interface.
// No dependencies; imported by every module of the block.
package cln_pkg;

   // Display geometry.
   localparam int ROWS    = 2;
   localparam int COLUMNS = 16;

   // Request kinds.
   localparam logic [2:0] KIND_INIT   = 3'd0;
   localparam logic [2:0] KIND_DEINIT = 3'd1;
   localparam logic [2:0] KIND_CMD    = 3'd2;
   localparam logic [2:0] KIND_DATA   = 3'd3;
   localparam logic [2:0] KIND_CURSOR = 3'd4;

   // Register indexes.
   localparam logic [2:0] CSR_STANDARD_DELAY = 3'd0;
   localparam logic [2:0] CSR_LONG_DELAY     = 3'd1;
   localparam logic [2:0] CSR_POWER_ON_DELAY = 3'd2;
   localparam logic [2:0] CSR_INIT_LONG_STEP = 3'd3;
   localparam logic [2:0] CSR_INIT_SHORT_STEP = 3'd4;

   // Display commands and address constants.
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_HOME      = 8'h02;
   localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
   localparam logic [7:0] ROW_BASE_ODD  = 8'h40;
   localparam logic [3:0] NIB_WAKE      = 4'h3;
   localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;

   // Step counter: init runs 4 wake nibbles and 5 bytes.
   localparam int          STEP_W          = 4;
   localparam logic [3:0]  FIRST_CMD_STEP  = 4'd4;
   localparam logic [3:0]  LAST_INIT_STEP  = 4'd13;
   localparam logic [3:0]  LAST_BYTE_STEP  = 4'd1;
   localparam logic [16:0] WAIT_MAX        = 17'h0FFFF;

   typedef enum logic [1:0] {
      JOB_INIT,
      JOB_PINS_LOW,
      JOB_BYTE
   } job_kind_type;

   // One request being turned into beats.
   typedef struct packed {
      logic               valid;
      job_kind_type       kind;
      logic               rs;
      logic [7:0]         value;
      logic [STEP_W-1:0]  step;
   } job_type;

   // Configuration register file contents.
   typedef struct packed {
      logic [15:0] standard_delay_us;
      logic [15:0] long_delay_us;
      logic [15:0] power_on_delay_us;
      logic [15:0] init_long_step_us;
      logic [15:0] init_short_step_us;
   } csr_type;

   // Commands sent after the wake nibbles of the init sequence.
   function automatic logic [7:0] init_cmd(input logic [2:0] idx);
      logic [7:0] cmd;
      case (idx)
         3'd0:    cmd = 8'h28;
         3'd1:    cmd = 8'h08;
         3'd2:    cmd = CMD_CLEAR;
         3'd3:    cmd = 8'h06;
         3'd4:    cmd = 8'h0C;
         default: cmd = 8'h00;
      endcase
      return cmd;
   endfunction

   // True on the final beat of a job.
   function automatic logic job_last(input job_kind_type kind, input logic [STEP_W-1:0] step);
      logic last;
      case (kind)
         JOB_INIT:     last = (step == LAST_INIT_STEP);
         JOB_BYTE:     last = (step == LAST_BYTE_STEP);
         JOB_PINS_LOW: last = 1'b1;
         default:      last = 1'b1;
      endcase
      return last;
   endfunction

   // Set-address command for a clamped row and column.
   function automatic logic [7:0] cursor_addr(input logic signed [7:0] row,
                                              input logic signed [7:0] column);
      logic signed [7:0] r;
      logic signed [7:0] c;
      logic [7:0]        base;
      r = row;
      if (row < 0)
         r = 8'sd0;
      else if (row >= 8'(ROWS))
         r = 8'(ROWS - 1);
      c = column;
      if (column < 0)
         c = 8'sd0;
      else if (column >= 8'(COLUMNS))
         c = 8'(COLUMNS - 1);
      base = r[0] ? ROW_BASE_ODD : 8'h00;
      return CMD_SET_DDRAM | (base + $unsigned(c));
   endfunction

endpackage

// ===== hdl/cln_csr.sv =====
// Configuration register file for the character LCD nibble interface.
// Depends on cln_pkg for the register indexes and the register struct.
module cln_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [2:0]      csr_index,
   input  logic [15:0]     csr_write_data,
   output cln_pkg::csr_type csr
);
   import cln_pkg::*;

   csr_type csr_ff;
   csr_type csr_in;

   // Decode the write index; writes beyond the list are dropped.
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_STANDARD_DELAY:  csr_in.standard_delay_us  = csr_write_data;
            CSR_LONG_DELAY:      csr_in.long_delay_us      = csr_write_data;
            CSR_POWER_ON_DELAY:  csr_in.power_on_delay_us  = csr_write_data;
            CSR_INIT_LONG_STEP:  csr_in.init_long_step_us  = csr_write_data;
            CSR_INIT_SHORT_STEP: csr_in.init_short_step_us = csr_write_data;
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.standard_delay_us  <= 16'd100;
         csr_ff.long_delay_us      <= 16'd3000;
         csr_ff.power_on_delay_us  <= 16'd50000;
         csr_ff.init_long_step_us  <= 16'd5000;
         csr_ff.init_short_step_us <= 16'd500;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

// ===== hdl/cln_job.sv =====
// Request register, ready flag and beat step counter.
// Depends on cln_pkg for the kind codes, job struct and cursor address function.
module cln_job (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_kind,
   input  logic [7:0]          req_byte_value,
   input  logic signed [7:0]   req_row,
   input  logic signed [7:0]   req_column,
   input  logic                advance,
   output cln_pkg::job_type    job,
   output logic                ready_flag
);
   import cln_pkg::*;

   job_type job_ff;
   job_type job_in;
   logic    job_valid_ff;
   logic    job_valid_in;
   logic    ready_ff;
   logic    ready_in;
   logic    job_done;
   logic    accept;
   logic    produces;

   // The held request frees the input as its final beat leaves.
   assign job_done  = advance && job_last(job_ff.kind, job_ff.step);
   assign req_stall = job_valid_ff && !job_done;
   assign accept    = req_valid && !req_stall;

   // Before init only an init request gives any beat.
   always_comb begin
      produces = 1'b0;
      if (req_kind == KIND_INIT)
         produces = 1'b1;
      else if (ready_ff && (req_kind inside {KIND_DEINIT, KIND_CMD, KIND_DATA, KIND_CURSOR}))
         produces = 1'b1;
   end

   // Load a new request or step through the current one.
   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      ready_in     = ready_ff;
      if (advance)
         job_in.step = job_ff.step + 1'b1;
      if (job_done)
         job_valid_in = 1'b0;
      if (accept) begin
         job_in.step  = '0;
         job_in.rs    = 1'b0;
         job_in.value = req_byte_value;
         job_in.kind  = JOB_BYTE;
         case (req_kind)
            KIND_INIT: begin
               job_in.kind = JOB_INIT;
               ready_in    = 1'b1;
            end
            KIND_DEINIT: begin
               job_in.kind = JOB_PINS_LOW;
               if (ready_ff)
                  ready_in = 1'b0;
            end
            KIND_DATA: begin
               job_in.rs = 1'b1;
            end
            KIND_CURSOR: begin
               job_in.value = cursor_addr(req_row, req_column);
            end
            default: begin
               job_in.kind = JOB_BYTE;
            end
         endcase
         job_valid_in = produces;
      end
      job_in.valid = job_valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         ready_ff     <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         ready_ff     <= ready_in;
      end
   end

   // Request payload needs no reset.
   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   always_comb begin
      job       = job_ff;
      job.valid = job_valid_ff;
   end

   assign ready_flag = ready_ff;

endmodule

// ===== hdl/cln_out.sv =====
// Beat generator and result register: one beat per cycle while not stalled.
// Depends on cln_pkg for the job and register structs and the init command table.
module cln_out (
   input  logic              clock,
   input  logic              reset,
   input  cln_pkg::job_type  job,
   input  cln_pkg::csr_type  csr,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_reg_select,
   output logic [3:0]        rsp_nibble,
   output logic [15:0]       rsp_wait_before_us,
   output logic [15:0]       rsp_wait_after_us,
   output logic              rsp_pins_low,
   output logic              rsp_last
);
   import cln_pkg::*;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        load;
   logic [3:0]  cmd_offset;
   logic [7:0]  cmd;
   logic        byte_phase;
   logic        rs;
   logic        long_cmd;
   logic [16:0] settle_sum;
   logic [15:0] settle;
   logic        reg_select_in;
   logic [3:0]  nibble_in;
   logic [15:0] wait_before_in;
   logic [15:0] wait_after_in;
   logic        pins_low_in;
   logic        last_in;
   logic        reg_select_ff;
   logic [3:0]  nibble_ff;
   logic [15:0] wait_before_ff;
   logic [15:0] wait_after_ff;
   logic        pins_low_ff;
   logic        last_ff;

   // The result register takes a beat when empty or being drained.
   assign load    = !rsp_valid_ff || !rsp_stall;
   assign advance = load && job.valid;

   // Byte being sent: an init command from the table or the request's own byte.
   assign cmd_offset = job.step - FIRST_CMD_STEP;
   assign cmd        = (job.kind == JOB_INIT) ? init_cmd(cmd_offset[3:1]) : job.value;
   assign byte_phase = (job.kind == JOB_BYTE) || (job.step >= FIRST_CMD_STEP);
   assign rs         = (job.kind == JOB_BYTE) && job.rs;

   // Settle time after a low nibble, with the long wait after clear or home.
   assign long_cmd   = !rs && ((cmd == CMD_CLEAR) || (cmd == CMD_HOME));
   assign settle_sum = {1'b0, csr.standard_delay_us}
                     + (long_cmd ? {1'b0, csr.long_delay_us} : 17'd0);
   assign settle     = (settle_sum > WAIT_MAX) ? WAIT_MAX[15:0] : settle_sum[15:0];

   // Fields of the next beat.
   always_comb begin
      reg_select_in  = 1'b0;
      nibble_in      = 4'h0;
      wait_before_in = 16'd0;
      wait_after_in  = 16'd0;
      pins_low_in    = 1'b0;
      last_in        = job_last(job.kind, job.step);
      if (job.kind == JOB_PINS_LOW) begin
         pins_low_in = 1'b1;
      end else if (byte_phase) begin
         reg_select_in = rs;
         nibble_in     = job.step[0] ? cmd[3:0] : cmd[7:4];
         wait_after_in = job.step[0] ? settle : 16'd0;
      end else begin
         // Wake-up nibbles that force the four-bit mode.
         nibble_in      = (job.step[1:0] == 2'd3) ? NIB_FOUR_BIT : NIB_WAKE;
         wait_before_in = (job.step[1:0] == 2'd0) ? csr.power_on_delay_us : 16'd0;
         wait_after_in  = job.step[1] ? csr.init_short_step_us : csr.init_long_step_us;
      end
   end

   assign rsp_valid_in = load ? job.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Beat payload holds while stalled.
   always_ff @(posedge clock) begin
      if (load) begin
         reg_select_ff  <= reg_select_in;
         nibble_ff      <= nibble_in;
         wait_before_ff <= wait_before_in;
         wait_after_ff  <= wait_after_in;
         pins_low_ff    <= pins_low_in;
         last_ff        <= last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reg_select     = reg_select_ff;
   assign rsp_nibble         = nibble_ff;
   assign rsp_wait_before_us = wait_before_ff;
   assign rsp_wait_after_us  = wait_after_ff;
   assign rsp_pins_low       = pins_low_ff;
   assign rsp_last           = last_ff;

endmodule

// ===== hdl/char_lcd_nibble_interface.sv =====
// Top level of the character LCD nibble interface: request register, beat generator, CSRs.
// Depends on cln_pkg, cln_csr, cln_job, cln_out and the assertion macro header.
//
//   channel | ports         | direction | beat
//   req     | req_*         | in        | one display request (kind, byte, row, column)
//   rsp     | rsp_*         | out       | one nibble transfer or pins-low action
//   csr     | csr_*         | in        | one register write, no wait
//
// One beat leaves the result register per cycle while rsp is not stalled; a request holds
// the input until its final beat is taken: 14 beats for init, 2 for a byte or cursor move,
// 1 for deinit; a request giving no beat does not hold it; the step counter counts them.
// Synchronous reset clears the ready flag, the held request and the result valid.
// A stall on rsp holds the current beat and, once the request register is busy, req.
`include "char_lcd_nibble_interface_defines.svh"
module char_lcd_nibble_interface (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_kind,
   input  logic [7:0]        req_byte_value,
   input  logic signed [7:0] req_row,
   input  logic signed [7:0] req_column,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_reg_select,
   output logic [3:0]        rsp_nibble,
   output logic [15:0]       rsp_wait_before_us,
   output logic [15:0]       rsp_wait_after_us,
   output logic              rsp_pins_low,
   output logic              rsp_last,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_write_data
);
   import cln_pkg::*;

   csr_type csr;
   job_type job;
   logic    advance;
   logic    ready_flag;

   // Configuration registers.
   cln_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr              (csr)
   );

   // Request register and step counter.
   cln_job u_job (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_byte_value (req_byte_value),
      .req_row        (req_row),
      .req_column     (req_column),
      .advance        (advance),
      .job            (job),
      .ready_flag     (ready_flag)
   );

   // Beat generation and result register.
   cln_out u_out (
      .clock              (clock),
      .reset              (reset),
      .job                (job),
      .csr                (csr),
      .advance            (advance),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_reg_select     (rsp_reg_select),
      .rsp_nibble         (rsp_nibble),
      .rsp_wait_before_us (rsp_wait_before_us),
      .rsp_wait_after_us  (rsp_wait_after_us),
      .rsp_pins_low       (rsp_pins_low),
      .rsp_last           (rsp_last)
   );

   // An accepted init request leaves the display ready.
   `CLN_ASSERT(a_init_sets_ready, clock, reset, (req_valid && !req_stall && req_kind == KIND_INIT) |=> ready_flag, "init did not set ready flag")
   // The step counter never runs past the init sequence.
   `CLN_ASSERT(a_step_bound, clock, reset, job.valid |-> (job.step <= LAST_INIT_STEP), "step counter out of range")
   // A pins-low beat is a lone final beat with no transfer data.
   `CLN_ASSERT(a_pins_low_last, clock, reset, (rsp_valid && rsp_pins_low) |-> (rsp_last && rsp_nibble == 4'h0), "pins-low beat malformed")
   // Only the first wake nibble carries a wait before it.
   `CLN_ASSERT_NEVER(a_wait_before_wake, clock, reset, rsp_valid && rsp_wait_before_us != 16'd0 && (rsp_nibble != NIB_WAKE || rsp_reg_select), "wait before on a non-wake beat")

endmodule

// ===== tb/tb_char_lcd_nibble_interface.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the character LCD nibble interface (char_lcd_nibble_interface).
// Depends on cln_pkg and the block's RTL; predicts every nibble transfer and checks it in order.
module tb_char_lcd_nibble_interface;
   import cln_pkg::*;

   // Kinds the block must ignore.
   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_MID   = 3'd6;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

   // Commands sent by the init sequence after the wake nibbles, first one in the top byte.
   localparam logic [39:0] SETUP_COMMANDS = {8'h28, 8'h08, CMD_CLEAR, 8'h06, 8'h0C};

   // Cycles allowed after the last expected transfer for a request that gives none.
   localparam int SETTLE_CYCLES   = 16;
   localparam int HOLD_OFF_CYCLES = 300;
   // No beat moves for at most a hold-off plus a few bursts; this is several times that.
   localparam int STALL_LIMIT     = 2000;

   // One nibble transfer or pins-low action as seen on the result port.
   typedef struct packed {
      logic        rs;
      logic [3:0]  nibble;
      logic [15:0] wait_before;
      logic [15:0] wait_after;
      logic        pins_low;
      logic        last;
   } lcd_transfer_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [2:0]        req_kind = KIND_INIT;
   logic [7:0]        req_byte_value = 8'h00;
   logic signed [7:0] req_row = 8'sd0;
   logic signed [7:0] req_column = 8'sd0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_reg_select;
   logic [3:0]        rsp_nibble;
   logic [15:0]       rsp_wait_before_us;
   logic [15:0]       rsp_wait_after_us;
   logic              rsp_pins_low;
   logic              rsp_last;
   logic              csr_write_enable = 1'b0;
   logic [2:0]        csr_index = CSR_STANDARD_DELAY;
   logic [15:0]       csr_write_data = 16'h0000;

   // Predictor copy of the display state and delay registers.
   logic              display_ready;
   logic [15:0]       standard_delay;
   logic [15:0]       long_delay;
   logic [15:0]       power_on_delay;
   logic [15:0]       init_long_step;
   logic [15:0]       init_short_step;

   lcd_transfer_type  expected_transfers[$];
   int                mismatch_count = 0;
   int                transfers_checked = 0;
   int                requests_sent = 0;
   int                requests_answered = 0;
   int                delay_settings_used = 1;
   int                quiet_cycles = 0;
   bit                sender_idling = 1'b1;
   bit                rsp_idling = 1'b1;
   bit                hold_off_request = 1'b0;
   bit                hold_off_active = 1'b0;

   char_lcd_nibble_interface DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_byte_value     (req_byte_value),
      .req_row            (req_row),
      .req_column         (req_column),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_reg_select     (rsp_reg_select),
      .rsp_nibble         (rsp_nibble),
      .rsp_wait_before_us (rsp_wait_before_us),
      .rsp_wait_after_us  (rsp_wait_after_us),
      .rsp_pins_low       (rsp_pins_low),
      .rsp_last           (rsp_last),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   function automatic void queue_transfer(input logic rs, input logic [3:0] nibble,
                                          input logic [15:0] before_us,
                                          input logic [15:0] after_us,
                                          input logic pins_low, input logic last);
      lcd_transfer_type t;
      t.rs          = rs;
      t.nibble      = nibble;
      t.wait_before = before_us;
      t.wait_after  = after_us;
      t.pins_low    = pins_low;
      t.last        = last;
      expected_transfers.push_back(t);
   endfunction

   // A byte goes out high nibble first; clear and home commands add the long delay.
   function automatic void queue_byte(input logic rs, input logic [7:0] value, input logic last);
      logic [16:0] settle;
      settle = {1'b0, standard_delay};
      if (!rs && (value == CMD_CLEAR || value == CMD_HOME))
         settle = settle + {1'b0, long_delay};
      queue_transfer(rs, value[7:4], 16'd0, 16'd0, 1'b0, 1'b0);
      queue_transfer(rs, value[3:0], 16'd0, settle[16] ? 16'hFFFF : settle[15:0], 1'b0, last);
   endfunction

   // Queues the transfers one accepted request causes and returns how many.
   function automatic int predict_transfers(input logic [2:0] kind, input logic [7:0] value,
                                            input logic signed [7:0] row,
                                            input logic signed [7:0] column);
      int         first;
      int         r;
      int         c;
      logic [7:0] base;
      first = expected_transfers.size();
      r     = int'(row);
      c     = int'(column);
      if (kind == KIND_INIT) begin
         queue_transfer(1'b0, NIB_WAKE, power_on_delay, init_long_step, 1'b0, 1'b0);
         queue_transfer(1'b0, NIB_WAKE, 16'd0, init_long_step, 1'b0, 1'b0);
         queue_transfer(1'b0, NIB_WAKE, 16'd0, init_short_step, 1'b0, 1'b0);
         queue_transfer(1'b0, NIB_FOUR_BIT, 16'd0, init_short_step, 1'b0, 1'b0);
         for (int i = 0; i < 5; i++)
            queue_byte(1'b0, SETUP_COMMANDS[39 - 8 * i -: 8], i == 4);
         display_ready = 1'b1;
      end else if (display_ready) begin
         case (kind)
            KIND_DEINIT: begin
               queue_transfer(1'b0, 4'h0, 16'd0, 16'd0, 1'b1, 1'b1);
               display_ready = 1'b0;
            end
            KIND_CMD:  queue_byte(1'b0, value, 1'b1);
            KIND_DATA: queue_byte(1'b1, value, 1'b1);
            KIND_CURSOR: begin
               if (r < 0) r = 0;
               if (r > ROWS - 1) r = ROWS - 1;
               if (c < 0) c = 0;
               if (c > COLUMNS - 1) c = COLUMNS - 1;
               base = (r == 0) ? 8'h00 : ROW_BASE_ODD;
               queue_byte(1'b0, CMD_SET_DDRAM | (base + c[7:0]), 1'b1);
            end
            default: ;
         endcase
      end
      return expected_transfers.size() - first;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("ERROR at %0t, transfer %0d: %s is %0d, expected %0d",
               $realtime, transfers_checked, what, got, want);
      mismatch_count++;
   endtask

   // Every beat taken from the result port is compared with the oldest expectation.
   always @(posedge clock) begin : check_transfers
      lcd_transfer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_transfers.size() == 0) begin
            report_mismatch("unexpected beat, nibble", 32'(rsp_nibble), 0);
         end else begin
            want = expected_transfers.pop_front();
            if (rsp_reg_select !== want.rs)
               report_mismatch("reg_select", 32'(rsp_reg_select), 32'(want.rs));
            if (rsp_nibble !== want.nibble)
               report_mismatch("nibble", 32'(rsp_nibble), 32'(want.nibble));
            if (rsp_wait_before_us !== want.wait_before)
               report_mismatch("wait_before_us", 32'(rsp_wait_before_us),
                               32'(want.wait_before));
            if (rsp_wait_after_us !== want.wait_after)
               report_mismatch("wait_after_us", 32'(rsp_wait_after_us),
                               32'(want.wait_after));
            if (rsp_pins_low !== want.pins_low)
               report_mismatch("pins_low", 32'(rsp_pins_low), 32'(want.pins_low));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
         transfers_checked++;
      end
   end

   // The run ends as failed when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("Timeout: no beat moved for %0d cycles, %0d transfers outstanding",
                  STALL_LIMIT, expected_transfers.size());
         $display("tb_char_lcd_nibble_interface: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- receiver

   // Random stall bursts, a long hold-off on request, and no stalls when idling is off.
   initial begin : receiver
      int span;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_active = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
            hold_off_active  = 1'b0;
         end else if (rsp_idling && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            span = $urandom_range(1, 15);
            repeat (span) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            span = rsp_idling ? $urandom_range(1, 20) : 1;
            repeat (span) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- sender

   // Offers one request and predicts its transfers once it is taken. Valid stays high
   // afterwards so that a following request can go out back to back; await_idle lowers it.
   task automatic offer_request(input logic [2:0] kind, input logic [7:0] value,
                                input logic signed [7:0] row, input logic signed [7:0] column);
      int gap;
      int count;
      if (sender_idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_byte_value <= value;
      req_row        <= row;
      req_column     <= column;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      count = predict_transfers(kind, value, row, column);
      requests_sent++;
      if (count > 0)
         requests_answered++;
   endtask

   // Stops offering, waits for every expected transfer, then lets a request with no
   // transfers finish inside the block.
   task automatic await_idle();
      req_valid <= 1'b0;
      while (expected_transfers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes leave the enable high between them; program_delays lowers it.
   task automatic write_register(input logic [2:0] index, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      case (index)
         CSR_STANDARD_DELAY:  standard_delay  = value;
         CSR_LONG_DELAY:      long_delay      = value;
         CSR_POWER_ON_DELAY:  power_on_delay  = value;
         CSR_INIT_LONG_STEP:  init_long_step  = value;
         CSR_INIT_SHORT_STEP: init_short_step = value;
         default: ;
      endcase
   endtask

   task automatic program_delays(input logic [15:0] standard, input logic [15:0] extra,
                                 input logic [15:0] power_on, input logic [15:0] long_step,
                                 input logic [15:0] short_step);
      write_register(CSR_STANDARD_DELAY, standard);
      write_register(CSR_LONG_DELAY, extra);
      write_register(CSR_POWER_ON_DELAY, power_on);
      write_register(CSR_INIT_LONG_STEP, long_step);
      write_register(CSR_INIT_SHORT_STEP, short_step);
      csr_write_enable <= 1'b0;
      delay_settings_used++;
   endtask

   // Mostly well-formed traffic on a ready display, with some noise and re-inits.
   task automatic random_request();
      int                pick;
      logic [2:0]        kind;
      logic [7:0]        value;
      logic signed [7:0] row;
      logic signed [7:0] column;
      pick  = $urandom_range(0, 99);
      value = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 0) begin
         row    = 8'(int'($urandom_range(0, 7)) - 3);
         column = 8'(int'($urandom_range(0, 23)) - 3);
      end else begin
         row    = 8'($urandom_range(0, 255));
         column = 8'($urandom_range(0, 255));
      end
      if (!display_ready)
         kind = (pick < 75) ? KIND_INIT : 3'($urandom_range(KIND_DEINIT, KIND_SPARE_LAST));
      else if (pick < 35)
         kind = KIND_DATA;
      else if (pick < 60)
         kind = KIND_CMD;
      else if (pick < 80)
         kind = KIND_CURSOR;
      else if (pick < 85)
         kind = KIND_DEINIT;
      else if (pick < 90)
         kind = KIND_INIT;
      else
         kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      if (kind == KIND_CMD && $urandom_range(0, 5) == 0)
         value = $urandom_range(0, 1) ? CMD_CLEAR : CMD_HOME;
      offer_request(kind, value, row, column);
   endtask

   // ---------------------------------------------------------------- tests

   // Before init every request but init is dropped.
   task automatic test_requests_before_init();
      offer_request(KIND_CMD, 8'h0C, 8'sd0, 8'sd0);
      offer_request(KIND_DATA, 8'h41, 8'sd0, 8'sd0);
      offer_request(KIND_CURSOR, 8'h00, 8'sd1, 8'sd5);
      offer_request(KIND_DEINIT, 8'h00, 8'sd0, 8'sd0);
      offer_request(KIND_SPARE_LAST, 8'hFF, -8'sd1, -8'sd1);
      await_idle();
   endtask

   // Init from cold and init again while already ready.
   task automatic test_init_sequence();
      offer_request(KIND_INIT, 8'h00, 8'sd0, 8'sd0);
      offer_request(KIND_INIT, 8'hFF, 8'sd0, 8'sd0);
      await_idle();
   endtask

   // Byte extremes, the two long-delay commands, and the long-delay values and 8'hFF as data.
   task automatic test_byte_transfers();
      offer_request(KIND_CMD, 8'h00, 8'sd0, 8'sd0);
      offer_request(KIND_CMD, 8'hFF, 8'sd0, 8'sd0);
      offer_request(KIND_CMD, CMD_CLEAR, 8'sd0, 8'sd0);
      offer_request(KIND_CMD, CMD_HOME, 8'sd0, 8'sd0);
      offer_request(KIND_DATA, CMD_CLEAR, 8'sd0, 8'sd0);
      offer_request(KIND_DATA, CMD_HOME, 8'sd0, 8'sd0);
      offer_request(KIND_DATA, 8'hFF, 8'sd0, 8'sd0);
      await_idle();
   endtask

   // Cursor rows and columns below, at and beyond the display edges.
   task automatic test_cursor_clamping();
      offer_request(KIND_CURSOR, 8'h00, -8'sd128, -8'sd128);
      offer_request(KIND_CURSOR, 8'h00, 8'sd0, 8'sd0);
      offer_request(KIND_CURSOR, 8'h00, 8'sd1, 8'sd15);
      offer_request(KIND_CURSOR, 8'h00, 8'sd2, 8'sd16);
      offer_request(KIND_CURSOR, 8'hFF, 8'sd127, 8'sd127);
      await_idle();
   endtask

   // Unused kinds give nothing and leave the display ready.
   task automatic test_spare_kinds();
      offer_request(KIND_SPARE_FIRST, 8'h55, 8'sd0, 8'sd0);
      offer_request(KIND_SPARE_MID, 8'hAA, 8'sd0, 8'sd0);
      offer_request(KIND_SPARE_LAST, 8'hFF, 8'sd0, 8'sd0);
      offer_request(KIND_DATA, 8'h5A, 8'sd0, 8'sd0);
      await_idle();
   endtask

   // Deinit drops pins, then requests are ignored until the next init.
   task automatic test_deinit();
      offer_request(KIND_DEINIT, 8'hFF, 8'sd0, 8'sd0);
      offer_request(KIND_CMD, 8'h41, 8'sd0, 8'sd0);
      offer_request(KIND_INIT, 8'h00, 8'sd0, 8'sd0);
      await_idle();
   endtask

   // All delays at zero, at maximum, and a sum that just overflows 16 bits.
   task automatic test_delay_extremes();
      for (int setting = 0; setting < 3; setting++) begin
         case (setting)
            0: program_delays(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            1: program_delays(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            default: program_delays(16'h8000, 16'h8000, 16'd1, 16'h7FFF, 16'd2);
         endcase
         offer_request(KIND_INIT, 8'h00, 8'sd0, 8'sd0);
         offer_request(KIND_CMD, CMD_HOME, 8'sd0, 8'sd0);
         offer_request(KIND_DATA, CMD_CLEAR, 8'sd0, 8'sd0);
         await_idle();
      end
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_receiver_hold_off();
      hold_off_request = 1'b1;
      while (!hold_off_active) @(posedge clock);
      for (int i = 0; i < 6; i++)
         offer_request((i % 2 == 0) ? KIND_CMD : KIND_DATA, 8'($urandom_range(0, 255)),
                       8'sd0, 8'sd0);
      await_idle();
   endtask

   // Random traffic in three delay settings, with occasional pauses until drained.
   task automatic test_random_traffic();
      int target;
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1)
            program_delays(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                           16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
                           16'($urandom_range(0, 200)));
         else
            program_delays(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)));
         target = requests_answered + 20;
         while (requests_answered < target) begin
            random_request();
            if ($urandom_range(0, 24) == 0)
               await_idle();
         end
         await_idle();
      end
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_full_rate();
      int target;
      sender_idling = 1'b0;
      rsp_idling    = 1'b0;
      target = requests_answered + 10;
      while (requests_answered < target)
         random_request();
      await_idle();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      display_ready   = 1'b0;
      standard_delay  = 16'd100;
      long_delay      = 16'd3000;
      power_on_delay  = 16'd50000;
      init_long_step  = 16'd5000;
      init_short_step = 16'd500;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_requests_before_init();
      test_init_sequence();
      test_byte_transfers();
      test_cursor_clamping();
      test_spare_kinds();
      test_deinit();
      test_delay_extremes();
      test_receiver_hold_off();
      test_random_traffic();
      test_full_rate();

      $display("Covered %0d requests (%0d with transfers) and %0d checked transfers",
               requests_sent, requests_answered, transfers_checked);
      $display("over %0d delay settings, with random stalls, a long hold-off and drains.",
               delay_settings_used);
      if (mismatch_count == 0)
         $display("tb_char_lcd_nibble_interface: done, clean");
      else
         $display("tb_char_lcd_nibble_interface: done, errors");
      $finish;
   end

endmodule
